### hw/rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

	localparam int FIELD_W = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       req_type;
		logic signed [FIELD_W-1:0] a_real;
		logic signed [FIELD_W-1:0] a_imag;
		logic signed [FIELD_W-1:0] b_real;
		logic signed [FIELD_W-1:0] b_imag;
	} req_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_real;
		logic signed [FIELD_W-1:0] res_imag;
		logic                      saturated;
		logic                      div_by_zero;
	} rsp_t;

endpackage

### hw/rtl/cau_front.sv
// Front pipeline: products, sums and sign-magnitude conversion (three stages).
module cau_front import cau_pkg::*; #(
	parameter int DW   = 16,
	parameter int FRAC = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  req_t            req,
	output logic            v_s3,
	output op_t             op_s3,
	output logic            dz_s3,
	output logic            neg_re_s3,
	output logic [2*DW-1:0] mag_re_s3,
	output logic            neg_im_s3,
	output logic [2*DW-1:0] mag_im_s3,
	output logic [2*DW-1:0] den_s3
);

	localparam int PW = 2 * DW;
	localparam int SW = 2 * DW + 1;

	logic [31:0] ar_w, ai_w, br_w, bi_w;
	logic signed [DW-1:0] ar, ai, br, bi;

	assign ar_w = {16'h0000, req.a_real};
	assign ai_w = {16'h0000, req.a_imag};
	assign br_w = {16'h0000, req.b_real};
	assign bi_w = {16'h0000, req.b_imag};
	assign ar   = ar_w[DW-1:0];
	assign ai   = ai_w[DW-1:0];
	assign br   = br_w[DW-1:0];
	assign bi   = bi_w[DW-1:0];

	// stage 1: multipliers and add/sub
	logic                 v_s1;
	op_t                  op_s1;
	logic signed [PW-1:0] rr_s1, ii_s1, ir_s1, ri_s1, bb_s1, dd_s1;
	logic signed [DW:0]   sr_s1, si_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= req.req_type;
			rr_s1 <= PW'(ar) * PW'(br);
			ii_s1 <= PW'(ai) * PW'(bi);
			ir_s1 <= PW'(ai) * PW'(br);
			ri_s1 <= PW'(ar) * PW'(bi);
			bb_s1 <= PW'(br) * PW'(br);
			dd_s1 <= PW'(bi) * PW'(bi);
			if (req.req_type == OP_SUB) begin
				sr_s1 <= (DW+1)'(ar) - (DW+1)'(br);
				si_s1 <= (DW+1)'(ai) - (DW+1)'(bi);
			end else begin
				sr_s1 <= (DW+1)'(ar) + (DW+1)'(br);
				si_s1 <= (DW+1)'(ai) + (DW+1)'(bi);
			end
		end
	end

	// stage 2: product sums and divisor norm
	logic                 v_s2;
	op_t                  op_s2;
	logic signed [SW-1:0] re_s2, im_s2;
	logic [PW-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			den_s2 <= PW'(bb_s1) + PW'(dd_s1);
			unique case (op_s1)
				OP_MUL: begin
					re_s2 <= SW'(rr_s1) - SW'(ii_s1);
					im_s2 <= SW'(ir_s1) + SW'(ri_s1);
				end
				OP_DIV: begin
					re_s2 <= SW'(rr_s1) + SW'(ii_s1);
					im_s2 <= SW'(ir_s1) - SW'(ri_s1);
				end
				default: begin
					re_s2 <= SW'(sr_s1);
					im_s2 <= SW'(si_s1);
				end
			endcase
		end
	end

	// stage 3: rescale and sign-magnitude
	logic signed [SW-1:0] re_sh, im_sh, re_abs, im_abs;

	always_comb begin
		if (op_s2 == OP_MUL) begin
			re_sh = re_s2 >>> FRAC;
			im_sh = im_s2 >>> FRAC;
		end else begin
			re_sh = re_s2;
			im_sh = im_s2;
		end
		re_abs = re_sh[SW-1] ? -re_sh : re_sh;
		im_abs = im_sh[SW-1] ? -im_sh : im_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3     <= op_s2;
			dz_s3     <= (op_s2 == OP_DIV) && (den_s2 == '0);
			neg_re_s3 <= re_sh[SW-1];
			neg_im_s3 <= im_sh[SW-1];
			mag_re_s3 <= re_abs[PW-1:0];
			mag_im_s3 <= im_abs[PW-1:0];
			den_s3    <= den_s2;
		end
	end

endmodule

### hw/rtl/cau_div_stage.sv
// One restoring-division step for both quotient parts, registered.
module cau_div_stage import cau_pkg::*; #(
	parameter int DW   = 16,
	parameter int FRAC = 8,
	parameter int BIT  = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  op_t             op_i,
	input  logic            dz_i,
	input  logic            neg_re_i,
	input  logic [2*DW-1:0] mag_re_i,
	input  logic            neg_im_i,
	input  logic [2*DW-1:0] mag_im_i,
	input  logic [2*DW-1:0] den_i,
	input  logic [2*DW-1:0] rem_re_i,
	input  logic [2*DW-1:0] rem_im_i,
	input  logic [DW-1:0]   q_re_i,
	input  logic [DW-1:0]   q_im_i,
	input  logic            ovf_re_i,
	input  logic            ovf_im_i,
	output logic            v_o,
	output op_t             op_o,
	output logic            dz_o,
	output logic            neg_re_o,
	output logic [2*DW-1:0] mag_re_o,
	output logic            neg_im_o,
	output logic [2*DW-1:0] mag_im_o,
	output logic [2*DW-1:0] den_o,
	output logic [2*DW-1:0] rem_re_o,
	output logic [2*DW-1:0] rem_im_o,
	output logic [DW-1:0]   q_re_o,
	output logic [DW-1:0]   q_im_o,
	output logic            ovf_re_o,
	output logic            ovf_im_o
);

	localparam int MW = 2 * DW;

	logic           bit_re, bit_im;
	logic [MW:0]    try_re, try_im, dif_re, dif_im;
	logic           ge_re, ge_im;

	generate
		if (BIT >= FRAC) begin : g_num
			assign bit_re = mag_re_i[BIT-FRAC];
			assign bit_im = mag_im_i[BIT-FRAC];
		end else begin : g_pad
			assign bit_re = 1'b0;
			assign bit_im = 1'b0;
		end
	endgenerate

	always_comb begin
		try_re = {rem_re_i, bit_re};
		try_im = {rem_im_i, bit_im};
		dif_re = try_re - {1'b0, den_i};
		dif_im = try_im - {1'b0, den_i};
		ge_re  = try_re >= {1'b0, den_i};
		ge_im  = try_im >= {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_o     <= op_i;
			dz_o     <= dz_i;
			neg_re_o <= neg_re_i;
			neg_im_o <= neg_im_i;
			mag_re_o <= mag_re_i;
			mag_im_o <= mag_im_i;
			den_o    <= den_i;
			rem_re_o <= ge_re ? dif_re[MW-1:0] : try_re[MW-1:0];
			rem_im_o <= ge_im ? dif_im[MW-1:0] : try_im[MW-1:0];
			q_re_o   <= {q_re_i[DW-2:0], ge_re};
			q_im_o   <= {q_im_i[DW-2:0], ge_im};
			ovf_re_o <= ovf_re_i | q_re_i[DW-1];
			ovf_im_o <= ovf_im_i | q_im_i[DW-1];
		end
	end

endmodule

### hw/rtl/complex_arithmetic_unit_core.sv
// Complex add/sub/mul/div unit: top level with divider chain and output stage.
//
// Usage: words enter on req (req_valid/req_ready) holding the operation and
// two complex Q(DATA_WIDTH-FRAC_BITS).(FRAC_BITS) operands; one result word
// per request leaves on rsp (rsp_valid/rsp_ready) in request order.
// Path: three front stages (multiply, sum, sign-magnitude), one
// restoring-divider stage per dividend bit, and the output register. All
// operations use the same path.
// Throughput: one word per cycle; a new word is taken every cycle the
// output register is empty or being drained.
// Stall: when rsp_valid is high and rsp_ready low the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the pipe is empty and ready at once.
// Divide by zero returns zeros with div_by_zero set; clipped results set
// saturated.
module complex_arithmetic_unit_core import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int DW = DATA_WIDTH;
	localparam int MW = 2 * DW;
	localparam int ND = MW + FRAC_BITS;

	localparam logic [MW-1:0] LIM_P = MW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [MW-1:0] LIM_N = MW'(64'd1 << (DW - 1));

	logic en;
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	logic            v     [0:ND];
	op_t             op    [0:ND];
	logic            dz    [0:ND];
	logic            neg_re[0:ND];
	logic            neg_im[0:ND];
	logic [MW-1:0]   mag_re[0:ND];
	logic [MW-1:0]   mag_im[0:ND];
	logic [MW-1:0]   den   [0:ND];
	logic [MW-1:0]   rem_re[0:ND];
	logic [MW-1:0]   rem_im[0:ND];
	logic [DW-1:0]   q_re  [0:ND];
	logic [DW-1:0]   q_im  [0:ND];
	logic            ovf_re[0:ND];
	logic            ovf_im[0:ND];

	cau_front #(.DW(DW), .FRAC(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (req_valid),
		.req       (req),
		.v_s3      (v[0]),
		.op_s3     (op[0]),
		.dz_s3     (dz[0]),
		.neg_re_s3 (neg_re[0]),
		.mag_re_s3 (mag_re[0]),
		.neg_im_s3 (neg_im[0]),
		.mag_im_s3 (mag_im[0]),
		.den_s3    (den[0])
	);

	assign rem_re[0] = '0;
	assign rem_im[0] = '0;
	assign q_re[0]   = '0;
	assign q_im[0]   = '0;
	assign ovf_re[0] = 1'b0;
	assign ovf_im[0] = 1'b0;

	genvar j;
	generate
		for (j = 0; j < ND; j++) begin : g_div
			cau_div_stage #(.DW(DW), .FRAC(FRAC_BITS), .BIT(ND - 1 - j)) u_stage (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.v_i      (v[j]),
				.op_i     (op[j]),
				.dz_i     (dz[j]),
				.neg_re_i (neg_re[j]),
				.mag_re_i (mag_re[j]),
				.neg_im_i (neg_im[j]),
				.mag_im_i (mag_im[j]),
				.den_i    (den[j]),
				.rem_re_i (rem_re[j]),
				.rem_im_i (rem_im[j]),
				.q_re_i   (q_re[j]),
				.q_im_i   (q_im[j]),
				.ovf_re_i (ovf_re[j]),
				.ovf_im_i (ovf_im[j]),
				.v_o      (v[j+1]),
				.op_o     (op[j+1]),
				.dz_o     (dz[j+1]),
				.neg_re_o (neg_re[j+1]),
				.mag_re_o (mag_re[j+1]),
				.neg_im_o (neg_im[j+1]),
				.mag_im_o (mag_im[j+1]),
				.den_o    (den[j+1]),
				.rem_re_o (rem_re[j+1]),
				.rem_im_o (rem_im[j+1]),
				.q_re_o   (q_re[j+1]),
				.q_im_o   (q_im[j+1]),
				.ovf_re_o (ovf_re[j+1]),
				.ovf_im_o (ovf_im[j+1])
			);
		end
	endgenerate

	// clip and output register
	logic          is_div;
	logic [MW-1:0] m_re, m_im, c_re, c_im, s_re, s_im;
	logic          sat_re, sat_im;
	logic [31:0]   w_re, w_im;
	rsp_t          rsp_d;

	always_comb begin
		is_div = (op[ND] == OP_DIV);
		m_re   = is_div ? MW'(q_re[ND]) : mag_re[ND];
		m_im   = is_div ? MW'(q_im[ND]) : mag_im[ND];
		sat_re = (is_div && ovf_re[ND]) ||
		         (neg_re[ND] ? (m_re > LIM_N) : (m_re > LIM_P));
		sat_im = (is_div && ovf_im[ND]) ||
		         (neg_im[ND] ? (m_im > LIM_N) : (m_im > LIM_P));
		c_re   = sat_re ? (neg_re[ND] ? LIM_N : LIM_P) : m_re;
		c_im   = sat_im ? (neg_im[ND] ? LIM_N : LIM_P) : m_im;
		s_re   = neg_re[ND] ? -c_re : c_re;
		s_im   = neg_im[ND] ? -c_im : c_im;
		w_re   = 32'(s_re[DW-1:0]);
		w_im   = 32'(s_im[DW-1:0]);
		if (dz[ND]) begin
			rsp_d.res_real    = '0;
			rsp_d.res_imag    = '0;
			rsp_d.saturated   = 1'b0;
			rsp_d.div_by_zero = 1'b1;
		end else begin
			rsp_d.res_real    = w_re[FIELD_W-1:0];
			rsp_d.res_imag    = w_im[FIELD_W-1:0];
			rsp_d.saturated   = sat_re | sat_im;
			rsp_d.div_by_zero = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= v[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp <= rsp_d;
		end
	end

endmodule

### dv/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result word and compares it.
module cau_checker import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   op_seen [4],
	output int   sat_seen,
	output int   dz_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint POS_LIM = 32767;
	localparam longint NEG_LIM = -32768;

	rsp_t expected_q[$];

	function automatic logic signed [15:0] clamp16(input longint v, ref logic sat);
		if (v > POS_LIM) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (v < NEG_LIM) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// exact quotient of (num << 8) / den, truncated toward zero
	function automatic longint quot_trunc(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< 8) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic rsp_t predict_result(input req_t w);
		rsp_t r;
		longint ar, ai, br, bi, vr, vi, den;
		logic sat;
		ar = w.a_real;
		ai = w.a_imag;
		br = w.b_real;
		bi = w.b_imag;
		sat = 1'b0;
		r = '0;
		case (w.req_type)
			OP_ADD: begin
				vr = ar + br;
				vi = ai + bi;
			end
			OP_SUB: begin
				vr = ar - br;
				vi = ai - bi;
			end
			OP_MUL: begin
				vr = (ar * br - ai * bi) >>> 8;
				vi = (ai * br + ar * bi) >>> 8;
			end
			default: begin
				den = br * br + bi * bi;
				vr = 0;
				vi = 0;
				if (den == 0) begin
					r.div_by_zero = 1'b1;
				end else begin
					vr = quot_trunc(ar * br + ai * bi, den);
					vi = quot_trunc(ai * br - ar * bi, den);
				end
			end
		endcase
		r.res_real = clamp16(vr, sat);
		r.res_imag = clamp16(vi, sat);
		r.saturated = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("cau_checker: %s mismatch at %0t: got %0d, expected %0d", what, $time, got,
			want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		sat_seen = 0;
		dz_seen = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			expected_q.push_back(predict_result(req));
			op_seen[req.req_type]++;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.res_real !== want.res_real)
					report_mismatch("res_real", rsp.res_real, want.res_real);
				if (rsp.res_imag !== want.res_imag)
					report_mismatch("res_imag", rsp.res_imag, want.res_imag);
				if (rsp.saturated !== want.saturated)
					report_mismatch("saturated", rsp.saturated, want.saturated);
				if (rsp.div_by_zero !== want.div_by_zero)
					report_mismatch("div_by_zero", rsp.div_by_zero, want.div_by_zero);
				sat_seen += want.saturated;
				dz_seen += want.div_by_zero;
			end
		end
	end
endmodule

### dv/tb.sv
// Testbench top for the complex arithmetic unit: stimulus, flow control and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int LATENCY = 44;
	localparam int N_RANDOM = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   fail_count, pending, sat_seen, dz_seen;
	int   op_seen [4];
	bit   hold_off = 1'b0;

	always #5 clk = ~clk;

	complex_arithmetic_unit_core u_top (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	cau_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .op_seen(op_seen),
		.sat_seen(sat_seen), .dz_seen(dz_seen)
	);

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(input op_t op, input logic [15:0] ar, input logic [15:0] ai,
		input logic [15:0] br, input logic [15:0] bi);
		req_valid <= 1'b1;
		req <= '{op, ar, ai, br, bi};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_random();
		op_t op;
		logic [15:0] br, bi;
		op = op_t'($urandom_range(0, 3));
		br = pick_field();
		bi = pick_field();
		if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
			br = '0;
			bi = '0;
		end
		send_word(op, pick_field(), pick_field(), br, bi);
	endtask

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			rsp_ready <= 1'b0;
		else if (($time / 2000) % 3 == 0)
			rsp_ready <= 1'b1;
		else
			rsp_ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		int gap, burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every operation at the field extremes, plus zero divisors
		for (int op = 0; op < 4; op++) begin
			send_word(op_t'(op), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			send_word(op_t'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_word(op_t'(op), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
			send_word(op_t'(op), 16'h0100, 16'hff00, 16'h0080, 16'hffff);
			send_word(op_t'(op), 16'hffff, 16'h0001, 16'h0001, 16'h0000);
		end
		send_word(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
		send_word(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
		send_word(OP_DIV, 16'hfeff, 16'h0000, 16'h0200, 16'h0000);
		// long receiver hold-off while the sender keeps offering
		hold_off <= 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off <= 1'b0;
			end
			repeat (100) send_random();
		join
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) send_random();
			n += burst;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("tb: ops add/sub/mul/div = %0d/%0d/%0d/%0d", op_seen[0], op_seen[1],
			op_seen[2], op_seen[3]);
		$display("tb: results clipped %0d, zero divisors %0d, mismatches %0d", sat_seen,
			dz_seen, fail_count);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: timeout");
		$display("tb: FAIL");
		$finish;
	end
endmodule
